// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Both expand to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold on every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Whenever ante holds, cons must hold in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/fmms_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fmms_pkg;

  // Run limit and field widths
  localparam int MAX_ITEMS = 1024;
  localparam int MONTH_W   = 4;
  localparam int YEAR_W    = 16;
  localparam int TEMP_W    = 8;
  localparam int CNT_W     = 11;
  localparam int SUM_W     = 18;
  localparam int AVG_W     = 15;

  // Shared unit and divider sizing: |100 * sum| stays below 2**24
  localparam int ALU_W     = 25;
  localparam int DVD_W     = 24;
  localparam int REM_W     = 11;
  localparam int DIV_STEPS = DVD_W;
  localparam int DIV_CNT_W = 5;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MONTH_SELECT = 1'b0,
    REG_WHOLE_YEAR   = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t                   op;
    logic signed [ALU_W-1:0]   a;
    logic signed [ALU_W-1:0]   b;
  } alu_req_t;

endpackage

`default_nettype wire

// ----- rtl/fmms_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Record request channel
interface fmms_in_if;
  logic                                valid;
  logic                                ready;
  logic [fmms_pkg::MONTH_W-1:0]        rec_month;
  logic [fmms_pkg::YEAR_W-1:0]         rec_year;
  logic signed [fmms_pkg::TEMP_W-1:0]  temperature;
  logic                                last_item;

  modport source (output valid, rec_month, rec_year, temperature, last_item, input ready);
  modport sink   (input valid, rec_month, rec_year, temperature, last_item, output ready);
endinterface

// Statistics result channel
interface fmms_out_if;
  logic                                valid;
  logic                                ready;
  logic [fmms_pkg::CNT_W-1:0]          record_count;
  logic signed [fmms_pkg::SUM_W-1:0]   temp_sum;
  logic signed [fmms_pkg::AVG_W-1:0]   average_centi;
  logic signed [fmms_pkg::TEMP_W-1:0]  min_out;
  logic signed [fmms_pkg::TEMP_W-1:0]  max_out;
  logic                                no_data;
  logic [fmms_pkg::YEAR_W-1:0]         period_year;

  modport source (output valid, record_count, temp_sum, average_centi, min_out, max_out,
                  no_data, period_year, input ready);
  modport sink   (input valid, record_count, temp_sum, average_centi, min_out, max_out,
                  no_data, period_year, output ready);
endinterface

// Configuration write channel
interface fmms_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [fmms_pkg::CFG_IDX_W-1:0]      index;
  logic [fmms_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/fmms_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Shared add/subtract unit: min/max compares, sum, x100, abs, divide steps, sign fix
module fmms_alu (
  input  fmms_pkg::alu_req_t                   req,
  output logic signed [fmms_pkg::ALU_W-1:0]    res
);

  always_comb begin
    case (req.op)
      fmms_pkg::ALU_ADD: res = req.a + req.b;
      fmms_pkg::ALU_SUB: res = req.a - req.b;
      default:           res = req.a + req.b;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/filtered_min_max_mean_stats_unit.sv -----
// A record outside the filter is only captured; a counted record steps through min,
// max and sum (the first counted record of a run skips max). A last record then adds
// x100, sign, 24 divide steps, sign fix and hand-off, or hand-off alone with no data,
// plus any wait for the output register; all steps share one 25-bit add/subtract unit.
// A new record is taken only once the previous one is done; one run result per run.
// Reset (rst_n low, synchronous): run cleared, no result, month_select = 1, whole_year = 0.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module filtered_min_max_mean_stats_unit (
  input  wire              clk,
  input  wire              rst_n,
  fmms_in_if.sink          in_rec,
  fmms_out_if.source       out_res,
  fmms_cfg_if.sink         cfg_wr
);

  localparam int AW = fmms_pkg::ALU_W;
  localparam int TW = fmms_pkg::TEMP_W;
  localparam int SW = fmms_pkg::SUM_W;
  localparam int CW = fmms_pkg::CNT_W;
  localparam int DW = fmms_pkg::DVD_W;
  localparam int RW = fmms_pkg::REM_W;
  localparam int VW = fmms_pkg::AVG_W;

  typedef enum logic [3:0] {
    S_IDLE, S_MIN, S_MAX, S_SUM, S_M1, S_M2, S_ABS, S_DIV, S_SGN, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // Configuration
  logic [fmms_pkg::MONTH_W-1:0] month_sel_r, month_sel_nxt;
  logic                         whole_year_r, whole_year_nxt;

  // Run state
  logic [CW-1:0]                counted_r, counted_nxt;
  logic signed [SW-1:0]         sum_r, sum_nxt;
  logic signed [TW-1:0]         lowest_r, lowest_nxt;
  logic signed [TW-1:0]         highest_r, highest_nxt;
  logic [fmms_pkg::YEAR_W-1:0]  first_year_r, first_year_nxt;
  logic                         run_started_r, run_started_nxt;

  // Captured record
  logic signed [TW-1:0]         temp_r, temp_nxt;
  logic                         last_r, last_nxt;

  // Average datapath
  logic signed [AW-1:0]         acc_r, acc_nxt;
  logic [DW-1:0]                dvd_r, dvd_nxt;
  logic [RW-1:0]                rem_r, rem_nxt;
  logic [fmms_pkg::DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                         neg_r, neg_nxt;
  logic signed [VW-1:0]         avg_r, avg_nxt;

  // Result register
  logic                         out_valid_r, out_valid_nxt;
  logic [CW-1:0]                o_count_r, o_count_nxt;
  logic signed [SW-1:0]         o_sum_r, o_sum_nxt;
  logic signed [VW-1:0]         o_avg_r, o_avg_nxt;
  logic signed [TW-1:0]         o_min_r, o_min_nxt;
  logic signed [TW-1:0]         o_max_r, o_max_nxt;
  logic                         o_nodata_r, o_nodata_nxt;
  logic [fmms_pkg::YEAR_W-1:0]  o_year_r, o_year_nxt;

  fmms_pkg::alu_req_t           alu_req;
  logic signed [AW-1:0]         alu_res;

  logic                         in_take;
  logic                         rec_match;
  logic signed [AW-1:0]         temp_x, sum_x;

  fmms_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign in_rec.ready  = (state_r == S_IDLE);
  assign cfg_wr.ready  = 1'b1;
  assign in_take       = in_rec.valid && in_rec.ready;

  assign rec_match = whole_year_r || (in_rec.rec_month == month_sel_r);
  assign temp_x    = AW'(temp_r);
  assign sum_x     = AW'(sum_r);

  assign out_res.valid         = out_valid_r;
  assign out_res.record_count  = o_count_r;
  assign out_res.temp_sum      = o_sum_r;
  assign out_res.average_centi = o_avg_r;
  assign out_res.min_out       = o_min_r;
  assign out_res.max_out       = o_max_r;
  assign out_res.no_data       = o_nodata_r;
  assign out_res.period_year   = o_year_r;

  // Shared unit operand select
  always_comb begin
    alu_req.op = fmms_pkg::ALU_ADD;
    alu_req.a  = '0;
    alu_req.b  = '0;
    case (state_r)
      S_MIN: begin
        alu_req.op = fmms_pkg::ALU_SUB;
        alu_req.a  = temp_x;
        alu_req.b  = AW'(lowest_r);
      end
      S_MAX: begin
        alu_req.op = fmms_pkg::ALU_SUB;
        alu_req.a  = AW'(highest_r);
        alu_req.b  = temp_x;
      end
      S_SUM: begin
        alu_req.a  = sum_x;
        alu_req.b  = temp_x;
      end
      S_M1: begin
        alu_req.a  = sum_x <<< 6;
        alu_req.b  = sum_x <<< 5;
      end
      S_M2: begin
        alu_req.a  = acc_r;
        alu_req.b  = sum_x <<< 2;
      end
      S_ABS: begin
        alu_req.op = fmms_pkg::ALU_SUB;
        alu_req.b  = acc_r;
      end
      S_DIV: begin
        alu_req.op = fmms_pkg::ALU_SUB;
        alu_req.a  = AW'({rem_r, dvd_r[DW-1]});
        alu_req.b  = AW'(counted_r);
      end
      S_SGN: begin
        alu_req.op = fmms_pkg::ALU_SUB;
        alu_req.b  = AW'(dvd_r);
      end
      default: begin
        alu_req.op = fmms_pkg::ALU_ADD;
      end
    endcase
  end

  // Sequencer and datapath next state
  always_comb begin
    state_nxt       = state_r;
    month_sel_nxt   = month_sel_r;
    whole_year_nxt  = whole_year_r;
    counted_nxt     = counted_r;
    sum_nxt         = sum_r;
    lowest_nxt      = lowest_r;
    highest_nxt     = highest_r;
    first_year_nxt  = first_year_r;
    run_started_nxt = run_started_r;
    temp_nxt        = temp_r;
    last_nxt        = last_r;
    acc_nxt         = acc_r;
    dvd_nxt         = dvd_r;
    rem_nxt         = rem_r;
    div_cnt_nxt     = div_cnt_r;
    neg_nxt         = neg_r;
    avg_nxt         = avg_r;
    out_valid_nxt   = out_valid_r && !out_res.ready;
    o_count_nxt     = o_count_r;
    o_sum_nxt       = o_sum_r;
    o_avg_nxt       = o_avg_r;
    o_min_nxt       = o_min_r;
    o_max_nxt       = o_max_r;
    o_nodata_nxt    = o_nodata_r;
    o_year_nxt      = o_year_r;

    // Register writes
    if (cfg_wr.valid) begin
      if (cfg_wr.index == fmms_pkg::REG_MONTH_SELECT) begin
        month_sel_nxt = cfg_wr.data[fmms_pkg::MONTH_W-1:0];
      end
      if (cfg_wr.index == fmms_pkg::REG_WHOLE_YEAR) begin
        whole_year_nxt = cfg_wr.data[0];
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          temp_nxt = in_rec.temperature;
          last_nxt = in_rec.last_item;
          if (!run_started_r) begin
            first_year_nxt  = in_rec.rec_year;
            run_started_nxt = 1'b1;
          end
          if (rec_match && (counted_r < CW'(fmms_pkg::MAX_ITEMS))) begin
            state_nxt = S_MIN;
          end else if (in_rec.last_item) begin
            state_nxt = (counted_r != '0) ? S_M1 : S_OUT;
          end
        end
      end
      S_MIN: begin
        if (counted_r == '0) begin
          lowest_nxt  = temp_r;
          highest_nxt = temp_r;
          state_nxt   = S_SUM;
        end else begin
          if (alu_res[AW-1]) lowest_nxt = temp_r;
          state_nxt = S_MAX;
        end
      end
      S_MAX: begin
        if (alu_res[AW-1]) highest_nxt = temp_r;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        sum_nxt     = alu_res[SW-1:0];
        counted_nxt = counted_r + 1'b1;
        state_nxt   = last_r ? S_M1 : S_IDLE;
      end
      S_M1: begin
        acc_nxt   = alu_res;
        state_nxt = S_M2;
      end
      S_M2: begin
        acc_nxt   = alu_res;
        state_nxt = S_ABS;
      end
      S_ABS: begin
        neg_nxt     = acc_r[AW-1];
        dvd_nxt     = acc_r[AW-1] ? alu_res[DW-1:0] : acc_r[DW-1:0];
        rem_nxt     = '0;
        div_cnt_nxt = '0;
        state_nxt   = S_DIV;
      end
      // Restoring divide, one quotient bit per cycle
      S_DIV: begin
        if (alu_res[AW-1]) begin
          rem_nxt = {rem_r[RW-2:0], dvd_r[DW-1]};
          dvd_nxt = {dvd_r[DW-2:0], 1'b0};
        end else begin
          rem_nxt = alu_res[RW-1:0];
          dvd_nxt = {dvd_r[DW-2:0], 1'b1};
        end
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == fmms_pkg::DIV_CNT_W'(fmms_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_SGN;
        end
      end
      S_SGN: begin
        avg_nxt   = neg_r ? alu_res[VW-1:0] : dvd_r[VW-1:0];
        state_nxt = S_OUT;
      end
      // Hand the result over once the output register is free
      S_OUT: begin
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt = 1'b1;
          o_nodata_nxt  = (counted_r == '0);
          o_year_nxt    = first_year_r;
          if (counted_r == '0) begin
            o_count_nxt = '0;
            o_sum_nxt   = '0;
            o_avg_nxt   = '0;
            o_min_nxt   = '0;
            o_max_nxt   = '0;
          end else begin
            o_count_nxt = counted_r;
            o_sum_nxt   = sum_r;
            o_avg_nxt   = avg_r;
            o_min_nxt   = lowest_r;
            o_max_nxt   = highest_r;
          end
          counted_nxt     = '0;
          sum_nxt         = '0;
          lowest_nxt      = '0;
          highest_nxt     = '0;
          first_year_nxt  = '0;
          run_started_nxt = 1'b0;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, control and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      month_sel_r   <= fmms_pkg::MONTH_W'(1);
      whole_year_r  <= 1'b0;
      counted_r     <= '0;
      sum_r         <= '0;
      run_started_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      month_sel_r   <= month_sel_nxt;
      whole_year_r  <= whole_year_nxt;
      counted_r     <= counted_nxt;
      sum_r         <= sum_nxt;
      run_started_r <= run_started_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    lowest_r     <= lowest_nxt;
    highest_r    <= highest_nxt;
    first_year_r <= first_year_nxt;
    temp_r       <= temp_nxt;
    last_r       <= last_nxt;
    acc_r        <= acc_nxt;
    dvd_r        <= dvd_nxt;
    rem_r        <= rem_nxt;
    div_cnt_r    <= div_cnt_nxt;
    neg_r        <= neg_nxt;
    avg_r        <= avg_nxt;
    o_count_r    <= o_count_nxt;
    o_sum_r      <= o_sum_nxt;
    o_avg_r      <= o_avg_nxt;
    o_min_r      <= o_min_nxt;
    o_max_r      <= o_max_nxt;
    o_nodata_r   <= o_nodata_nxt;
    o_year_r     <= o_year_nxt;
  end

  // Checks
  `ASSERT_ALWAYS(a_count_cap, clk, rst_n,
                 counted_r <= CW'(fmms_pkg::MAX_ITEMS), "run count past limit")
  `ASSERT_IMPLIES(a_result_src, clk, rst_n,
                  $rose(out_valid_r), $past(state_r) == S_OUT, "result without finish step")
  `ASSERT_IMPLIES(a_nodata_zero, clk, rst_n, out_valid_r && o_nodata_r,
                  o_count_r == '0 && o_sum_r == '0 && o_min_r == '0 && o_max_r == '0,
                  "no-data result not cleared")
  `ASSERT_IMPLIES(a_avg_sign, clk, rst_n, out_valid_r && !o_nodata_r && !o_sum_r[SW-1],
                  !o_avg_r[VW-1], "average sign wrong")

endmodule

`default_nettype wire
